// File: rtl/indexed_insert_erase_array_defines.svh
// Assertion macros shared by the indexed insert/erase array.
`ifndef INDEXED_INSERT_ERASE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_ERASE_ARRAY_DEFINES_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define IIEA_ASSERT_NOW(label, cond, check) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error("assertion failed: cond -> check");

// Next-cycle implication, checked on the block clock outside reset.
`define IIEA_ASSERT_NEXT(label, cond, check) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error("assertion failed: cond => check");

`endif

// File: rtl/iiea_pkg.sv
// Types and constants of the indexed insert/erase array.
package iiea_pkg;

   // Storage geometry.
   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CIDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Fixed field widths of the channels.
   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int WORD_W = 32;
   localparam int OCNT_W = 6;

   // Width wide enough to compare indexes, positions and counts.
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   // Operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                     ins;
      logic                     ers;
      logic [IDX_W-1:0]         idx;
      logic signed [WORD_W-1:0] value;
   } cmd_type;

endpackage

// File: rtl/indexed_insert_erase_array.sv
// Top level of the indexed insert/erase array: control and the row of cells.
//
// Usage: an ordered list of up to CAPACITY signed 32-bit words. Each request item
// carries an operation (insert, erase or read), an index and a value. Insert puts
// the value at the index and moves later words up; erase removes the word at the
// index and moves later words down; read returns the word at the index.
// Every request item gives exactly one response item with ok, the read word (zero
// unless a read succeeds) and the length after the operation.
// Response: the result register is loaded when the request is accepted, so the
// response is valid in the cycle after. Throughput: one item per cycle unless stalled;
// every cell of the row loads from its neighbor, the new value or itself in the same
// cycle, and the read selects one cell. The response register frees in the cycle it is
// taken, so a new request is accepted in that same cycle.
// Stall: while a response waits under rsp_stall, req_stall is raised and the
// request side holds. Reset (synchronous) empties the list and the response
// register; stored words are not cleared, and req_stall is high during reset.
module indexed_insert_erase_array (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [iiea_pkg::OP_W-1:0]          req_op,
   input  logic [iiea_pkg::IDX_W-1:0]         req_index,
   input  logic signed [iiea_pkg::WORD_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_ok,
   output logic signed [iiea_pkg::WORD_W-1:0] rsp_read_value,
   output logic [iiea_pkg::OCNT_W-1:0]        rsp_count
);
   import iiea_pkg::*;
   `include "indexed_insert_erase_array_defines.svh"

   cmd_type                  cmd;
   logic [CNT_W-1:0]         fill;
   logic signed [WORD_W-1:0] cell_q [CAPACITY];
   logic signed [WORD_W-1:0] rd_word;
   logic [CIDX_W-1:0]        rd_sel;
   logic [CIDX_W-1:0]        ins_sel;

   // Control and result register.
   iiea_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_value      (req_value),
      .rd_word        (rd_word),
      .cmd            (cmd),
      .fill           (fill),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   // Row of cells; the ends see zero beyond the row.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_q;
      logic signed [WORD_W-1:0] right_q;

      if (g == 0) begin : g_first
         assign left_q = '0;
      end else begin : g_mid_l
         assign left_q = cell_q[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_q = '0;
      end else begin : g_mid_r
         assign right_q = cell_q[g+1];
      end

      iiea_cell u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .pos     (CIDX_W'(g)),
         .left_q  (left_q),
         .right_q (right_q),
         .q       (cell_q[g])
      );
   end

   // Read select; an index out of range is rejected by the control.
   assign rd_sel  = CIDX_W'(req_index);
   assign rd_word = cell_q[rd_sel];
   assign ins_sel = CIDX_W'(cmd.idx);

   // Checks on length bookkeeping, the inserted word and the response timing.
   `IIEA_ASSERT_NEXT(a_ins_grows, cmd.ins, fill == $past(fill) + CNT_W'(1))
   `IIEA_ASSERT_NEXT(a_ers_shrinks, cmd.ers, fill == $past(fill) - CNT_W'(1))
   `IIEA_ASSERT_NEXT(a_ins_stored, cmd.ins, cell_q[$past(ins_sel)] == $past(cmd.value))
   `IIEA_ASSERT_NEXT(a_rsp_follows, req_valid && !req_stall, rsp_valid)

endmodule

// File: rtl/iiea_cell.sv
// One storage cell of the row: holds a word, takes the new value or a neighbor's word.
module iiea_cell (
   input  logic                              clock,
   input  iiea_pkg::cmd_type                 cmd,
   input  logic [iiea_pkg::CIDX_W-1:0]       pos,
   input  logic signed [iiea_pkg::WORD_W-1:0] left_q,
   input  logic signed [iiea_pkg::WORD_W-1:0] right_q,
   output logic signed [iiea_pkg::WORD_W-1:0] q
);
   import iiea_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         idx_ext;

   assign pos_ext = CMP_W'(pos);
   assign idx_ext = CMP_W'(cmd.idx);

   // Insert moves cells above the index up; erase pulls cells from the index down.
   always_comb begin
      word_in = word_ff;
      if (cmd.ins) begin
         if (pos_ext == idx_ext) begin
            word_in = cmd.value;
         end else if (pos_ext > idx_ext) begin
            word_in = left_q;
         end
      end else if (cmd.ers && (pos_ext >= idx_ext)) begin
         word_in = right_q;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;

endmodule

// File: rtl/iiea_ctrl.sv
// Control of the array: length, operation checks, cell command and result register.
module iiea_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [iiea_pkg::OP_W-1:0]          req_op,
   input  logic [iiea_pkg::IDX_W-1:0]         req_index,
   input  logic signed [iiea_pkg::WORD_W-1:0] req_value,
   input  logic signed [iiea_pkg::WORD_W-1:0] rd_word,
   output iiea_pkg::cmd_type                  cmd,
   output logic [iiea_pkg::CNT_W-1:0]         fill,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_ok,
   output logic signed [iiea_pkg::WORD_W-1:0] rsp_read_value,
   output logic [iiea_pkg::OCNT_W-1:0]        rsp_count
);
   import iiea_pkg::*;

   logic                     fill_count_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_ok_ff;
   logic signed [WORD_W-1:0] rsp_read_value_ff;
   logic [OCNT_W-1:0]        rsp_count_ff;
   logic                     accept;
   logic                     ins_ok;
   logic                     ers_ok;
   logic                     rd_ok;
   logic [CMP_W-1:0]         idx_ext;
   logic [CMP_W-1:0]         cnt_ext;
   logic                     not_full;

   // An item is taken unless in reset or the result register is full and held.
   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign idx_ext  = CMP_W'(req_index);
   assign cnt_ext  = CMP_W'(count_ff);
   assign not_full = (count_ff != CNT_W'(CAPACITY));

   // Decode the operation and check it against the current length.
   always_comb begin
      ins_ok = 1'b0;
      ers_ok = 1'b0;
      rd_ok  = 1'b0;
      case (op_type'(req_op))
         OP_INSERT: ins_ok = not_full && (idx_ext <= cnt_ext);
         OP_ERASE:  ers_ok = (idx_ext < cnt_ext);
         OP_READ:   rd_ok  = (idx_ext < cnt_ext);
         default: begin
            ins_ok = 1'b0;
         end
      endcase
   end

   // Command to the cell row, only for an accepted item that succeeds.
   assign cmd.ins   = accept && ins_ok;
   assign cmd.ers   = accept && ers_ok;
   assign cmd.idx   = req_index;
   assign cmd.value = req_value;

   // Next length.
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.ers) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // The result register is loaded on accept and emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         fill_count_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_count_ff <= (count_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff         <= ins_ok || ers_ok || rd_ok;
         rsp_read_value_ff <= rd_ok ? rd_word : '0;
         rsp_count_ff      <= OCNT_W'(count_in);
      end
   end

   assign fill           = fill_count_ff ? count_ff : '0;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

// File: test/tb.sv
// Self-checking testbench for the indexed insert/erase array.
`timescale 1ns / 100ps

module tb;
   import iiea_pkg::*;

   // The op code that the block has no operation for.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Cycles without any accepted item before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;

   // Fields of one response item.
   typedef struct {
      logic                     ok;
      logic signed [WORD_W-1:0] read_value;
      logic [OCNT_W-1:0]        count;
   } list_answer_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op    = OP_INSERT;
   logic [IDX_W-1:0]         req_index = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_ok;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic [OCNT_W-1:0]        rsp_count;

   // Mirror of the stored list, kept in step with accepted requests.
   logic signed [WORD_W-1:0] list_words [CAPACITY];
   int                       list_len = 0;

   list_answer_type pending_answers [$];
   int              error_count = 0;
   int              idle_cycles = 0;
   int              stall_left  = 0;
   bit              idling      = 1'b1;

   indexed_insert_erase_array DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the mirrored list and returns the answer it must give.
   function automatic list_answer_type apply_list_op(input logic [OP_W-1:0] op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic signed [WORD_W-1:0] val);
      list_answer_type answer;
      int k;
      answer.ok         = 1'b0;
      answer.read_value = '0;
      case (op)
         OP_INSERT: begin
            if (list_len < CAPACITY && idx <= list_len) begin
               for (k = list_len; k > idx; k--) list_words[k] = list_words[k - 1];
               list_words[idx] = val;
               list_len++;
               answer.ok = 1'b1;
            end
         end
         OP_ERASE: begin
            if (list_len > 0 && idx < list_len) begin
               for (k = idx + 1; k < list_len; k++) list_words[k - 1] = list_words[k];
               list_len--;
               answer.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (idx < list_len) begin
               answer.read_value = list_words[idx];
               answer.ok         = 1'b1;
            end
         end
         default: ;
      endcase
      answer.count = OCNT_W'(list_len);
      return answer;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (!idling) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   // Offers one request item after an optional gap and waits until it is taken.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [WORD_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= idx;
      req_value <= val;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
   endtask

   // Random index up to the given bound, or anywhere in the field now and then.
   function automatic logic [IDX_W-1:0] pick_index(input int upper);
      if ($urandom_range(0, 99) < 12 || upper < 0) return IDX_W'($urandom_range(0, 63));
      return IDX_W'($urandom_range(0, upper));
   endfunction

   // Rejections on an empty list and the unused op code.
   task automatic test_empty_list();
      send_item(OP_ERASE, 6'd0, $urandom);
      send_item(OP_READ, 6'd0, $urandom);
      send_item(OP_INSERT, 6'd1, $urandom);
      send_item(OP_UNUSED, 6'd0, $urandom);
      send_item(OP_READ, 6'h3f, $urandom);
      send_item(OP_ERASE, 6'h3f, $urandom);
   endtask

   // Inserts at front, middle and end with extreme words, then reads and erases.
   task automatic test_insert_positions();
      send_item(OP_INSERT, 6'd0, 32'sh7fff_ffff);
      send_item(OP_INSERT, 6'd1, 32'sh8000_0000);
      send_item(OP_INSERT, 6'd0, -32'sd1);
      send_item(OP_INSERT, 6'd1, 32'sd0);
      send_item(OP_INSERT, 6'd4, 32'sh5a5a_a5a5);
      for (int i = 0; i <= 5; i++) send_item(OP_READ, IDX_W'(i), $urandom);
      send_item(OP_INSERT, 6'd6, $urandom);
      send_item(OP_ERASE, 6'd2, $urandom);
      send_item(OP_ERASE, 6'd0, $urandom);
      send_item(OP_ERASE, 6'd2, $urandom);
      send_item(OP_READ, 6'd0, $urandom);
      send_item(OP_READ, 6'd1, $urandom);
      send_item(OP_UNUSED, 6'h3f, -32'sd1);
      send_item(OP_ERASE, 6'd5, $urandom);
   endtask

   // Fills the list at random positions, then pushes against the full limit.
   task automatic test_fill_to_capacity();
      while (list_len < CAPACITY)
         send_item(OP_INSERT, IDX_W'($urandom_range(0, list_len)), $urandom);
      send_item(OP_INSERT, 6'd0, $urandom);
      send_item(OP_INSERT, IDX_W'(CAPACITY), $urandom);
      send_item(OP_INSERT, 6'h3f, $urandom);
      send_item(OP_READ, IDX_W'(CAPACITY - 1), $urandom);
      send_item(OP_READ, IDX_W'(CAPACITY), $urandom);
      send_item(OP_ERASE, IDX_W'(CAPACITY), $urandom);
      send_item(OP_READ, 6'd0, $urandom);
   endtask

   // Reads and erases at random positions until the list is empty.
   task automatic test_drain_to_empty();
      while (list_len > 0) begin
         if ($urandom_range(0, 2) == 0)
            send_item(OP_READ, IDX_W'($urandom_range(0, list_len - 1)), $urandom);
         else
            send_item(OP_ERASE, IDX_W'($urandom_range(0, list_len - 1)), $urandom);
      end
      send_item(OP_ERASE, 6'd0, $urandom);
      send_item(OP_READ, 6'd0, $urandom);
   endtask

   // Mixed traffic in segments that lean toward growing or shrinking the list.
   task automatic test_random_mix();
      int roll;
      bit grow;
      for (int seg = 0; seg < 6; seg++) begin
         grow   = (seg % 2 == 0);
         idling = (seg != 2);
         for (int n = 0; n < 50; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
               send_item(OP_UNUSED, IDX_W'($urandom_range(0, 63)), $urandom);
            else if (roll < 25)
               send_item(OP_READ, pick_index(list_len - 1), $urandom);
            else if (roll < (grow ? 85 : 40))
               send_item(OP_INSERT, pick_index(list_len), $urandom);
            else
               send_item(OP_ERASE, pick_index(list_len - 1), $urandom);
         end
      end
      idling = 1'b1;
   endtask

   // Random stall on the response side.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (idling && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   // Predicts each accepted request item and checks each accepted response item.
   always @(posedge clock) begin
      list_answer_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_answers.push_back(apply_list_op(req_op, req_index, req_value));
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected response item: ok %0d, read_value %0d, count %0d",
                      rsp_ok, rsp_read_value, rsp_count);
               error_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_ok);
                  error_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value mismatch: expected %0d, actual %0d",
                         want.read_value, rsp_read_value);
                  error_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count mismatch: expected %0d, actual %0d", want.count, rsp_count);
                  error_count++;
               end
            end
         end
      end
   end

   // Ends the run if no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL indexed_insert_erase_array");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < CAPACITY; i++) list_words[i] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_insert_positions();
      test_fill_to_capacity();
      test_drain_to_empty();
      test_random_mix();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS indexed_insert_erase_array");
      end else begin
         $display("FAIL indexed_insert_erase_array");
      end
      $finish;
   end

endmodule

// File: indexed_insert_erase_array.f
+incdir+rtl
rtl/iiea_pkg.sv
rtl/iiea_cell.sv
rtl/iiea_ctrl.sv
rtl/indexed_insert_erase_array.sv
test/tb.sv
